// ===== rtl/kst_pkg.sv =====
// Package for the keyboard scancode key tracker: operation and status codes,
// scancode constants and default sizes. No dependencies.
package kst_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int HOLD_BITS          = 16;
    localparam logic [HOLD_BITS-1:0] HOLD_RESET = 16'd30;

    localparam logic [15:0] NO_PREFIX    = 16'hFFFF;
    localparam logic [15:0] CODE_MASK    = 16'hFF7F;
    localparam logic [15:0] PAUSE_PREFIX = 16'h001D;
    localparam logic [15:0] PAUSE_CODE   = 16'h0045;
    localparam logic [7:0]  PAUSE_KEY    = 8'hC5;
    localparam logic [7:0]  FAKE_SHIFT   = 8'hAA;
    localparam logic [7:0]  EXT_BIT      = 8'h80;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_PREFIX   = 3'd1,
        ST_DISCARD  = 3'd2,
        ST_AUTOREL  = 3'd3,
        ST_NOCHANGE = 3'd4
    } status_t;

endpackage

// ===== rtl/keyboard_scancode_key_tracker.sv =====
// Keyboard scancode key tracker (scancode set 1): input word register, decode
// and state update, result register. Depends on kst_pkg.
//
//  channel   dir  payload                                          handshake
//  s_axis    in   tuser: operation; tdata: code, flags, read index  tvalid/tready
//  m_axis    out  tuser: status; tdata: key index, key down         tvalid/tready
//  cfg       in   pause hold ticks (16 bit)                         cfg_we
//
// One word per cycle sustained while m_axis does not stall; a word passes
// the input register, then the decode/update logic into the result register.
// The decode is one pass over the pressed map flops, prefix register and pause timer.
// Reset (rst_n low, async) empties both stages, clears the map, drops any
// prefix and saturates the timer; the hold register returns to 30.
// A stall on m_axis holds the result and then the input word; s_axis_tready
// drops only when both stages are full and the result is not being taken.
module keyboard_scancode_key_tracker #(
    parameter int TIMER_BITS = kst_pkg::TIMER_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] make_code, [16] flag_break, [17] flag_e0, [18] flag_e1,
    // [26:19] read_index, [31:27] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] key_index, [8] key_down, [15:9] zero
    output logic [15:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    input  logic        cfg_we,
    input  logic [kst_pkg::HOLD_BITS-1:0] cfg_wdata
);
    import kst_pkg::*;

    // compare width covers both the timer and the 16-bit hold limit
    localparam int CMP_BITS = (TIMER_BITS > HOLD_BITS) ? TIMER_BITS : HOLD_BITS;

    // input stage
    logic        in_valid_reg;
    op_t         op_reg;
    logic [15:0] code_reg;
    logic        brk_reg;
    logic        e0_reg;
    logic        e1_reg;
    logic [7:0]  ridx_reg;

    // state
    logic [255:0]           map_reg, map_next;
    logic [15:0]            prefix_reg, prefix_next;
    logic [TIMER_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [HOLD_BITS-1:0]   hold_reg;

    // result stage
    logic        out_valid_reg;
    logic [7:0]  idx_reg, idx_next;
    logic        down_reg, down_next;
    status_t     status_reg, status_next;

    logic advance;
    logic proc;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, down_reg, idx_reg};
    assign m_axis_tuser  = status_reg;

    // decode and state update for the word in the input register
    logic [7:0]            sc;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic                  timer_sat;
    logic                  over_limit;

    always_comb
    begin
        map_next    = map_reg;
        prefix_next = prefix_reg;
        elapsed_next = elapsed_reg;
        idx_next    = 8'd0;
        down_next   = 1'b0;
        status_next = ST_NOCHANGE;
        sc          = {e0_reg, code_reg[6:0]};
        timer_sat   = (elapsed_reg == {TIMER_BITS{1'b1}});
        elapsed_inc = timer_sat ? elapsed_reg : elapsed_reg + 1'b1;
        over_limit  = (CMP_BITS'(elapsed_inc) > CMP_BITS'(hold_reg)) ||
                      (elapsed_inc == {TIMER_BITS{1'b1}});

        unique case (op_reg)
            OP_REPORT:
            begin
                if (e1_reg)
                begin
                    prefix_next = code_reg;
                    status_next = ST_PREFIX;
                end
                else if (prefix_reg != NO_PREFIX)
                begin
                    // second half of an E1 sequence: only Pause make survives
                    prefix_next = NO_PREFIX;
                    if (e0_reg || brk_reg ||
                        ((prefix_reg & CODE_MASK) != PAUSE_PREFIX) ||
                        ((code_reg & CODE_MASK) != PAUSE_CODE))
                    begin
                        status_next = ST_DISCARD;
                    end
                    else
                    begin
                        elapsed_next       = '0;
                        map_next[PAUSE_KEY] = 1'b1;
                        idx_next           = PAUSE_KEY;
                        down_next          = 1'b1;
                        status_next        = ST_UPDATED;
                    end
                end
                else if (code_reg[15:8] != 8'd0 || sc == FAKE_SHIFT)
                begin
                    status_next = ST_DISCARD;
                end
                else
                begin
                    map_next[sc] = !brk_reg;
                    idx_next     = sc;
                    down_next    = !brk_reg;
                    status_next  = ST_UPDATED;
                end
            end
            OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (map_reg[PAUSE_KEY] && over_limit)
                begin
                    map_next[PAUSE_KEY] = 1'b0;
                    idx_next            = PAUSE_KEY;
                    status_next         = ST_AUTOREL;
                end
            end
            OP_READ:
            begin
                idx_next  = ridx_reg;
                down_next = map_reg[ridx_reg];
            end
            OP_CLEAR:
            begin
                map_next     = '0;
                prefix_next  = NO_PREFIX;
                elapsed_next = {TIMER_BITS{1'b1}};
            end
            default:
            begin
                status_next = ST_NOCHANGE;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg   <= op_t'(s_axis_tuser);
            code_reg <= s_axis_tdata[15:0];
            brk_reg  <= s_axis_tdata[16];
            e0_reg   <= s_axis_tdata[17];
            e1_reg   <= s_axis_tdata[18];
            ridx_reg <= s_axis_tdata[26:19];
        end
    end

    // tracker state and hold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg     <= '0;
            prefix_reg  <= NO_PREFIX;
            elapsed_reg <= {TIMER_BITS{1'b1}};
            hold_reg    <= HOLD_RESET;
        end
        else
        begin
            if (proc)
            begin
                map_reg     <= map_next;
                prefix_reg  <= prefix_next;
                elapsed_reg <= elapsed_next;
            end
            if (cfg_we)
            begin
                hold_reg <= cfg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            idx_reg    <= idx_next;
            down_reg   <= down_next;
            status_reg <= status_next;
        end
    end

    // checks
    a_clear_empties_map: assert property (@(posedge clk) disable iff (!rst_n)
        proc && op_reg == OP_CLEAR |=> map_reg == '0 && prefix_reg == NO_PREFIX)
        else $error("clear left keys pressed or a prefix pending");

    a_e1_holds_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        proc && op_reg == OP_REPORT && e1_reg |=> prefix_reg == $past(code_reg))
        else $error("E1 report did not store its prefix");

    a_autorel_releases: assert property (@(posedge clk) disable iff (!rst_n)
        proc && status_next == ST_AUTOREL |=> !map_reg[PAUSE_KEY] &&
        m_axis_tvalid && m_axis_tdata[7:0] == PAUSE_KEY && !m_axis_tdata[8])
        else $error("pause auto-release result or map out of step");

    a_update_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        proc && status_next == ST_UPDATED |=> map_reg[idx_reg] == down_reg)
        else $error("updated key state differs from map");

endmodule
